// ===== rtl/tkm_pkg.sv =====
// package for the triaxial kalman magnitude block
// shared widths, register indexes and controller command/status types; no dependencies
package tkm_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 24;
  localparam int unsigned CovW     = 26;
  localparam int unsigned GainW    = 24;
  localparam int unsigned RawW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 26;

  // error covariance after reset, 1.0 in Q2.24
  localparam logic [CovW-1:0] InitCovReset = 26'd16777216;

  localparam logic [CfgIdxW-1:0] RegProcNoise = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMeasNoise = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInitCov   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegGravity   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_AXIS, ST_COV, ST_SQSUM, ST_SQRT, ST_PEAK, ST_OUT
  } state_e;

  typedef struct packed {
    logic load;      // capture input beat, compute measurements and p1
    logic div_start; // start gain division
    logic div_step;  // one quotient bit
    logic axis_step; // update one axis
    logic cov_upd;   // covariance update
    logic sq_step;   // accumulate one square
    logic sqrt_start;
    logic sqrt_step; // one result bit
    logic peak_upd;
  } tkm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic axis_last;
    logic sq_last;
    logic sqrt_done;
  } tkm_sts_t;

endpackage

// ===== rtl/tkm_ctrl.sv =====
// controller state machine for the triaxial kalman magnitude block
// depends on tkm_pkg
module tkm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic             out_busy_i,
  input  tkm_pkg::tkm_sts_t sts_i,
  output tkm_pkg::tkm_cmd_t cmd_o,
  output logic             idle_o,
  output logic             out_load_o
);
  import tkm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    idle_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_AXIS;
      end
      ST_AXIS: begin
        cmd_o.axis_step = 1'b1;
        if (sts_i.axis_last) state_d = ST_COV;
      end
      ST_COV: begin
        cmd_o.cov_upd = 1'b1;
        state_d       = ST_SQSUM;
      end
      ST_SQSUM: begin
        cmd_o.sq_step = 1'b1;
        if (sts_i.sq_last) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_done) state_d = ST_PEAK;
      end
      ST_PEAK: begin
        cmd_o.peak_upd = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy_i) begin
          out_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_SQSUM && sts_i.sq_last) cmd_o.sqrt_start = 1'b1;
  end

endmodule

// ===== rtl/tkm_datapath.sv =====
// datapath: measurement scaling, gain divider, axis update, covariance,
// serial sum of squares and bit-serial square root; depends on tkm_pkg
module tkm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tkm_pkg::tkm_cmd_t             cmd_i,
  output tkm_pkg::tkm_sts_t             sts_o,
  input  logic [3*tkm_pkg::RawW-1:0]    raw_i,
  input  logic [tkm_pkg::DataW-1:0]     q_i,
  input  logic [tkm_pkg::DataW-1:0]     r_i,
  input  logic [tkm_pkg::CovW-1:0]      p0_i,
  input  logic signed [tkm_pkg::RawW-1:0] grav_i,
  input  logic                          cov_load_i,
  output logic [3*tkm_pkg::DataW-1:0]   est_o,
  output logic [tkm_pkg::DataW-1:0]     mag_o,
  output logic [tkm_pkg::DataW-1:0]     peak_o
);
  import tkm_pkg::*;

  localparam int unsigned DivW  = CovW + 1;       // den width
  localparam int unsigned QW    = GainW + 1;      // k up to 2^24
  localparam int unsigned SumW  = 2 * DataW + 2;
  localparam int unsigned SqW   = DataW + 1;      // isqrt of SumW bits
  localparam int unsigned SqCntW = $clog2(SqW + 1);
  localparam int unsigned DivCntW = $clog2(CovW + GainW);
  localparam int unsigned Shift = FracBits - 8;

  logic signed [DataW-1:0] meas_q [3];
  logic signed [DataW-1:0] est_q  [3];
  logic [CovW-1:0]  p_q, p1_q;
  logic [DivW-1:0]  den_q;
  logic [DivW:0]    rem_q;
  logic [QW-1:0]    quo_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [1:0]       ax_q;
  logic [SumW-1:0]  sum_q;
  logic [SumW-1:0]  srem_q;
  logic [SqW-1:0]   root_q;
  logic [SqCntW-1:0] scnt_q;
  logic [DataW-1:0] mag_q, peak_q;

  function automatic logic signed [DataW-1:0] sat24(input logic signed [DataW+1:0] v);
    logic signed [DataW+1:0] mx, mn;
    mx = (DataW+2)'(2**(DataW-1) - 1);
    mn = -(DataW+2)'(2**(DataW-1));
    if (v > mx)      return mx[DataW-1:0];
    else if (v < mn) return mn[DataW-1:0];
    else             return v[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] to_fixed(input logic signed [RawW:0] c);
    logic signed [RawW+Shift:0] w;
    w = (RawW+Shift+1)'(c) <<< Shift;
    if (RawW + Shift + 1 <= DataW + 2) return sat24((DataW+2)'(w));
    else if (w > (RawW+Shift+1)'(2**(DataW-1) - 1)) return DataW'(2**(DataW-1) - 1);
    else if (w < -(RawW+Shift+1)'(2**(DataW-1))) return DataW'(2**(DataW-1));
    else return w[DataW-1:0];
  endfunction

  // the update term fits before saturation checks in two extra bits
  function automatic logic signed [DataW+1:0] sat_upd(input logic signed [DataW+QW:0] v);
    logic signed [DataW+QW:0] mx, mn;
    mx = (DataW+QW+1)'(2**(DataW+1) - 1);
    mn = -(DataW+QW+1)'(2**(DataW+1));
    if (v > mx)      return mx[DataW+1:0];
    else if (v < mn) return mn[DataW+1:0];
    else             return v[DataW+1:0];
  endfunction

  // measurement and predicted covariance
  logic [CovW:0] p1_sum;
  assign p1_sum = {1'b0, p_q} + (CovW+1)'(q_i);

  // axis update: one 26x25 signed multiply
  logic signed [DataW:0]      diff;
  logic signed [DataW+QW:0]   prod;
  logic signed [DataW+QW:0]   upd;
  assign diff = (DataW+1)'(meas_q[ax_q]) - (DataW+1)'(est_q[ax_q]);
  assign prod = $signed({1'b0, quo_q}) * diff;
  assign upd  = (prod + (DataW+QW+1)'(2**(GainW-1))) >>> GainW;

  // covariance: (2^24 - k) * p1
  logic [QW-1:0]        omk;
  logic [QW+CovW-1:0]   pn_prod;
  logic [QW+CovW-1:0]   pn;
  assign omk     = QW'(2**GainW) - quo_q;
  assign pn_prod = omk * p1_q;
  assign pn      = (pn_prod + (QW+CovW)'(2**(GainW-1))) >> GainW;

  logic signed [DataW-1:0] sq_src;
  logic [2*DataW-1:0]      sq;
  assign sq_src = est_q[ax_q];
  assign sq     = $unsigned((2*DataW)'(sq_src) * (2*DataW)'(sq_src));

  // bit-serial isqrt, two radicand bits a step
  logic [SumW-1:0] stry;
  logic [SumW-1:0] srem_sh;
  assign srem_sh = {srem_q[SumW-3:0], sum_q[SumW-1 -: 2]};
  assign stry    = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q[0] <= '0; est_q[1] <= '0; est_q[2] <= '0;
      p_q      <= InitCovReset;
      peak_q   <= '0;
      ax_q     <= '0;
      dcnt_q   <= '0;
      scnt_q   <= '0;
    end else begin
      if (cov_load_i) p_q <= p0_i;
      if (cmd_i.load) begin
        meas_q[0] <= to_fixed((RawW+1)'($signed(raw_i[RawW-1:0])));
        meas_q[1] <= to_fixed((RawW+1)'($signed(raw_i[2*RawW-1:RawW])));
        meas_q[2] <= to_fixed((RawW+1)'($signed(raw_i[3*RawW-1:2*RawW])) - (RawW+1)'(grav_i));
        p1_q      <= p1_sum[CovW] ? {CovW{1'b1}} : p1_sum[CovW-1:0];
      end
      if (cmd_i.div_start) begin
        den_q  <= DivW'(p1_q) + DivW'(r_i);
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        // numerator bits: p1 then GainW zeros
        logic nb;
        logic [DivW:0] shifted;
        nb = (dcnt_q < DivCntW'(CovW)) ? p1_q[CovW-1-dcnt_q[$clog2(CovW)-1:0]] : 1'b0;
        shifted = {rem_q[DivW-1:0], nb};
        if (den_q != '0 && shifted >= {1'b0, den_q}) begin
          rem_q <= shifted - {1'b0, den_q};
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= shifted;
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 1'b1;
        if (sts_o.div_done) begin
          ax_q   <= '0;
          dcnt_q <= '0;
        end
      end
      if (cmd_i.axis_step) begin
        est_q[ax_q] <= sat24((DataW+2)'(est_q[ax_q]) + (DataW+2)'(sat_upd(upd)));
        ax_q        <= sts_o.axis_last ? 2'd0 : ax_q + 1'b1;
      end
      if (cmd_i.cov_upd) begin
        p_q   <= (pn > (QW+CovW)'(2**CovW - 1)) ? {CovW{1'b1}} : pn[CovW-1:0];
        sum_q <= '0;
        ax_q  <= '0;
      end
      if (cmd_i.sq_step) begin
        sum_q <= sum_q + SumW'(sq);
        ax_q  <= ax_q + 1'b1;
      end
      if (cmd_i.sqrt_start) begin
        srem_q <= '0;
        root_q <= '0;
        scnt_q <= '0;
        sum_q  <= sum_q + SumW'(sq);
      end
      if (cmd_i.sqrt_step) begin
        sum_q <= {sum_q[SumW-3:0], 2'b00};
        if (srem_sh >= stry) begin
          srem_q <= srem_sh - stry;
          root_q <= {root_q[SqW-2:0], 1'b1};
        end else begin
          srem_q <= srem_sh;
          root_q <= {root_q[SqW-2:0], 1'b0};
        end
        scnt_q <= scnt_q + 1'b1;
      end
      if (cmd_i.peak_upd) begin
        if (mag_q > peak_q) peak_q <= mag_q;
      end
    end
  end

  always_comb begin
    mag_q = root_q[SqW-1] ? {DataW{1'b1}} : root_q[DataW-1:0];
  end

  assign sts_o.div_done  = (dcnt_q == DivCntW'(CovW + GainW - 1));
  assign sts_o.axis_last = (ax_q == 2'd2);
  assign sts_o.sq_last   = (ax_q == 2'd2);
  assign sts_o.sqrt_done = (scnt_q == SqCntW'(SqW - 1));

  assign est_o  = {est_q[2], est_q[1], est_q[0]};
  assign mag_o  = mag_q;
  assign peak_o = (mag_q > peak_q) ? mag_q : peak_q;

endmodule

// ===== rtl/triaxial_kalman_magnitude.sv =====
// steps from input beat to result: prep, bit-serial gain divider, 3 axis updates,
// covariance update, 3 squares, a 25-step square root, peak and load;
// one item at a time: a new beat is taken once the previous result is in the
// output register; a stalled result holds it off
// asynchronous active-low reset loads register reset values and the
// initial covariance, clears the estimates and the peak hold
module triaxial_kalman_magnitude (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // raw_accel_x, raw_accel_y, raw_accel_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [119:0] m_axis_tdata,  // filtered_x/y/z, magnitude, peak_magnitude
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [25:0] cfg_data_i
);
  import tkm_pkg::*;

  logic [DataW-1:0] q_q, r_q;
  logic signed [RawW-1:0] grav_q;
  logic [3*RawW-1:0] raw_q;
  logic cfg_fire, cov_load, in_fire, idle, out_load;
  tkm_cmd_t cmd;
  tkm_sts_t sts;
  logic [3*DataW-1:0] est;
  logic [DataW-1:0] mag, peak;
  logic [119:0] out_q;
  logic out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  // initial covariance goes straight into the covariance register
  assign cov_load    = cfg_fire && (cfg_index_i == RegInitCov);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= DataW'(16777);
      r_q    <= DataW'(2517);
      grav_q <= RawW'(256);
    end else if (cfg_fire) begin
      case (cfg_index_i)
        RegProcNoise: q_q    <= cfg_data_i[DataW-1:0];
        RegMeasNoise: r_q    <= cfg_data_i[DataW-1:0];
        RegGravity:   grav_q <= cfg_data_i[RawW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && idle;

  always_ff @(posedge clk_i) begin
    if (in_fire) raw_q <= s_axis_tdata;
  end

  tkm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (in_fire),
    .out_busy_i (out_valid_q && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle),
    .out_load_o (out_load)
  );

  // measurements are captured with the beat itself, straight from s_axis_tdata via load in idle
  tkm_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .sts_o      (sts),
    .raw_i      (in_fire ? s_axis_tdata : raw_q),
    .q_i        (q_q),
    .r_i        (r_q),
    .p0_i       (cfg_data_i[CovW-1:0]),
    .grav_i     (grav_q),
    .cov_load_i (cov_load),
    .est_o      (est),
    .mag_o      (mag),
    .peak_o     (peak)
  );

  // output register; peak_o already includes this magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= {peak, mag, est};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
